### rtl/bcv_pkg.sv
// Shared types and constants for the box clip visibility test.
// Used by every file of the block but bcv_out_if; depends on nothing.
package bcv_pkg;

  localparam int COORD_W = 24;          // Q15.8 box and offset coordinates
  localparam int PT_W = COORD_W + 1;    // corner plus offset, Q16.8
  localparam int COEF_W = 16;           // Q5.10 matrix entry
  localparam int PROD_W = COEF_W + PT_W;
  localparam int SUM_W = PROD_W + 2;
  localparam int ONE_SHIFT = 8;         // homogeneous 1 is 256 in Q.8
  localparam int N_AXES = 3;
  localparam int N_ROWS = 4;
  localparam int N_CORNERS = 8;
  localparam int CORNER_W = $clog2(N_CORNERS);
  localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(N_CORNERS - 1);

  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W = 3;
  localparam int IDX_LSB = 3;           // registers on 8-byte strides

  typedef enum logic [IDX_W-1:0] {
    REG_ROW0 = 3'd0,
    REG_ROW1 = 3'd1,
    REG_ROW2 = 3'd2,
    REG_ROW3 = 3'd3,
    REG_MODE = 3'd4
  } bcv_reg_e;

  localparam logic MODE_FULL = 1'b0;
  localparam logic MODE_XZ = 1'b1;

  // Identity matrix at reset.
  localparam logic [DATA_W-1:0] ROW0_RESET = 64'h0000_0000_0000_0400;
  localparam logic [DATA_W-1:0] ROW1_RESET = 64'h0000_0000_0400_0000;
  localparam logic [DATA_W-1:0] ROW2_RESET = 64'h0000_0400_0000_0000;
  localparam logic [DATA_W-1:0] ROW3_RESET = 64'h0400_0000_0000_0000;

  typedef struct packed {
    logic [N_ROWS-1:0][DATA_W-1:0] row;
    logic                          mode;
  } bcv_cfg_t;

  // Travels with each corner down the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } bcv_tag_t;

endpackage

### rtl/bcv_in_if.sv
// Input channel: one box with its offset per transaction.
// Depends on bcv_pkg for field widths.
interface bcv_in_if import bcv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] box_min_x;
  logic signed [COORD_W-1:0] box_min_y;
  logic signed [COORD_W-1:0] box_min_z;
  logic signed [COORD_W-1:0] box_max_x;
  logic signed [COORD_W-1:0] box_max_y;
  logic signed [COORD_W-1:0] box_max_z;
  logic signed [COORD_W-1:0] offset_x;
  logic signed [COORD_W-1:0] offset_y;
  logic signed [COORD_W-1:0] offset_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           offset_x, offset_y, offset_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           offset_x, offset_y, offset_z,
    output ready
  );
endinterface

### rtl/bcv_out_if.sv
// Result channel: one visibility flag per transaction.
// Self-contained.
interface bcv_out_if ();
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

### rtl/box_clip_visibility_test_top.sv
// Box clip visibility test, top level.
// item channel: one box (min and max corners) plus an offset per transaction.
// result channel: one visible flag per box, in input order.
// APB-style port: clip matrix rows 0..3 at byte addresses 0x00..0x18, test
// mode at 0x20; writes in the access phase, pready always high. Write only
// while no box is in flight.
// The corner sequencer sends one corner a cycle, while the pipeline advances,
// into a single shared matrix multiply array, so eight corners set the pace
// per box; a new box is taken in the cycle its predecessor's last corner issues.
// An accepted box's result passes the corner stage, product, row sum and
// magnitude stages, then the output register.
// Reset clears all valid bits and loads the identity matrix and full mode.
// When the receiver stalls, the result is held in the output register and
// every pipeline stage freezes; nothing is lost or repeated.
// Depends on bcv_pkg, the channel interfaces and the four submodules.
module box_clip_visibility_test_top import bcv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  bcv_in_if.sink            item,
  bcv_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  bcv_cfg_t                cfg;
  logic                    adv;
  bcv_tag_t                s0_tag;
  bcv_tag_t                s3_tag;
  logic signed [PT_W-1:0]  s0_pt [N_AXES];
  logic [SUM_W-1:0]        s3_mag [N_ROWS];

  bcv_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcv_corner_gen u_corner (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .item (item),
    .tag  (s0_tag),
    .pt   (s0_pt)
  );

  bcv_transform u_xform (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .cfg     (cfg),
    .tag_in  (s0_tag),
    .pt      (s0_pt),
    .tag_out (s3_tag),
    .mag     (s3_mag)
  );

  bcv_clip_test u_test (
    .clk    (clk),
    .rst    (rst),
    .mode   (cfg.mode),
    .tag    (s3_tag),
    .mag    (s3_mag),
    .adv    (adv),
    .result (result)
  );

`ifndef NO_ASSERTIONS
  // A stall must freeze the pipeline tail.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s3_tag))
    else $error("pipeline tag moved during stall");

  // A new result appears only when a box's last corner was tested.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(adv && s3_tag.valid && s3_tag.last))
    else $error("result without a last corner");

  // The corner stage only issues while the pipeline advances.
  a_issue_on_adv: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s0_tag))
    else $error("corner issued during stall");
`endif

endmodule

### rtl/bcv_cfg_regs.sv
// APB-style register file: four clip matrix rows and the test mode.
// Depends on bcv_pkg.
module bcv_cfg_regs import bcv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output bcv_cfg_t          cfg
);

  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx = paddr[IDX_LSB +: IDX_W];
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row[0] <= ROW0_RESET;
      cfg.row[1] <= ROW1_RESET;
      cfg.row[2] <= ROW2_RESET;
      cfg.row[3] <= ROW3_RESET;
      cfg.mode <= MODE_FULL;
    end else if (wr_en) begin
      case (idx)
        REG_ROW0: cfg.row[0] <= pwdata;
        REG_ROW1: cfg.row[1] <= pwdata;
        REG_ROW2: cfg.row[2] <= pwdata;
        REG_ROW3: cfg.row[3] <= pwdata;
        REG_MODE: cfg.mode <= pwdata[0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW0: prdata = cfg.row[0];
      REG_ROW1: prdata = cfg.row[1];
      REG_ROW2: prdata = cfg.row[2];
      REG_ROW3: prdata = cfg.row[3];
      REG_MODE: prdata = {{(DATA_W-1){1'b0}}, cfg.mode};
      default:  prdata = '0;
    endcase
  end

endmodule

### rtl/bcv_corner_gen.sv
// Holds the accepted box and issues its eight offset corners, one per cycle while adv is high.
// Depends on bcv_pkg and bcv_in_if.
module bcv_corner_gen import bcv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  bcv_in_if.sink                 item,
  output bcv_tag_t               tag,
  output logic signed [PT_W-1:0] pt [N_AXES]
);

  logic signed [COORD_W-1:0] lo [N_AXES];
  logic signed [COORD_W-1:0] hi [N_AXES];
  logic signed [COORD_W-1:0] off [N_AXES];
  logic                      busy;
  logic [CORNER_W-1:0]       cnt;
  logic                      issue_last;

  assign issue_last = busy && adv && (cnt == LAST_CORNER);
  // Take the next box while idle or as the last corner of the current one leaves.
  assign item.ready = !busy || issue_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (item.valid && item.ready) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (issue_last) begin
      busy <= 1'b0;
    end else if (busy && adv) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      lo[0] <= item.box_min_x;
      lo[1] <= item.box_min_y;
      lo[2] <= item.box_min_z;
      hi[0] <= item.box_max_x;
      hi[1] <= item.box_max_y;
      hi[2] <= item.box_max_z;
      off[0] <= item.offset_x;
      off[1] <= item.offset_y;
      off[2] <= item.offset_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else if (adv) begin
      tag.valid <= busy;
      tag.last <= cnt == LAST_CORNER;
    end
  end

  // Corner bit a picks max over min on axis a.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < N_AXES; a++) begin
        pt[a] <= (cnt[a] ? PT_W'(hi[a]) : PT_W'(lo[a])) + PT_W'(off[a]);
      end
    end
  end

endmodule

### rtl/bcv_transform.sv
// Multiplies each corner by the clip matrix and takes coordinate magnitudes.
// Three register stages: products, row sums, magnitudes. Depends on bcv_pkg.
module bcv_transform import bcv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  bcv_cfg_t               cfg,
  input  bcv_tag_t               tag_in,
  input  logic signed [PT_W-1:0] pt [N_AXES],
  output bcv_tag_t               tag_out,
  output logic [SUM_W-1:0]       mag [N_ROWS]
);

  bcv_tag_t                  tag1;
  bcv_tag_t                  tag2;
  logic signed [PROD_W-1:0]  prod [N_ROWS][N_ROWS];
  logic signed [SUM_W-1:0]   sum [N_ROWS];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag_out <= '0;
    end else if (adv) begin
      tag1 <= tag_in;
      tag2 <= tag1;
      tag_out <= tag2;
    end
  end

  // Column 3 meets the homogeneous 1, a plain shift.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < N_ROWS; r++) begin
        for (int a = 0; a < N_AXES; a++) begin
          prod[r][a] <= $signed(cfg.row[r][COEF_W*a +: COEF_W]) * pt[a];
        end
        prod[r][3] <= PROD_W'($signed({cfg.row[r][COEF_W*3 +: COEF_W],
                                       {ONE_SHIFT{1'b0}}}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < N_ROWS; r++) begin
        sum[r] <= SUM_W'(prod[r][0]) + SUM_W'(prod[r][1])
                + SUM_W'(prod[r][2]) + SUM_W'(prod[r][3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < N_ROWS; r++) begin
        mag[r] <= sum[r][SUM_W-1] ? SUM_W'(-sum[r]) : SUM_W'(sum[r]);
      end
    end
  end

endmodule

### rtl/bcv_clip_test.sv
// Tests each corner against the clip volume, ORs the eight verdicts and
// holds the result in the output register. Depends on bcv_pkg, bcv_out_if.
module bcv_clip_test import bcv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             mode,
  input  bcv_tag_t         tag,
  input  logic [SUM_W-1:0] mag [N_ROWS],
  output logic             adv,
  bcv_out_if.source        result
);

  logic acc;
  logic ok;

  // Freeze the whole pipeline only while a result waits to be taken.
  assign adv = !result.valid || result.ready;

  assign ok = (mag[3] != '0) && (mag[0] < mag[3]) && (mag[2] < mag[3])
           && ((mode == MODE_XZ) || (mag[1] < mag[3]));

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (adv && tag.valid) begin
        if (tag.last) begin
          result.valid <= 1'b1;
          acc <= 1'b0;
        end else begin
          acc <= acc || ok;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tag.valid && tag.last) begin
      result.visible <= acc || ok;
    end
  end

endmodule
